// ===== design/lspc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LED strip pixel colour package
// Shared types, codes and colour helpers for the pixel colour pipeline.
// ----------------------------------------------------------------------------
package lspc_pkg;

    // Pattern codes held in the mode register
    localparam logic [2:0] MODE_FILL          = 3'd0;
    localparam logic [2:0] MODE_WIPE          = 3'd1;
    localparam logic [2:0] MODE_POLICE        = 3'd2;
    localparam logic [2:0] MODE_RAINBOW       = 3'd3;
    localparam logic [2:0] MODE_RAINBOW_CYCLE = 3'd4;
    localparam logic [2:0] MODE_CHASE         = 3'd5;
    localparam logic [2:0] MODE_CHASE_RAINBOW = 3'd6;
    // Spare code: every pixel stays dark
    localparam logic [2:0] MODE_UNUSED        = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_PATTERN_MODE = 2'd0;
    localparam logic [1:0] CFG_PIXEL_COUNT  = 2'd1;
    localparam logic [1:0] CFG_BASE_COLOR   = 2'd2;

    // Field widths
    localparam int STEP_W  = 10;
    localparam int PHASE_W = 2;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int RGB_W   = 24;
    localparam int CHAN_W  = 8;

    // Pipelined divider shape: 8 quotient bits, 2 per stage
    localparam int QUO_W          = 8;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

    // Colour wheel constants
    localparam logic [7:0] WHEEL_THIRD      = 8'd85;
    localparam logic [7:0] WHEEL_TWO_THIRDS = 8'd170;
    localparam logic [7:0] CHAN_FULL        = 8'd255;

    localparam logic [RGB_W-1:0] RGB_RED  = 24'hFF0000;
    localparam logic [RGB_W-1:0] RGB_BLUE = 24'h0000FF;

    // Side information that travels beside the divider
    typedef struct packed {
        logic [7:0]       step_lo;
        logic             lit;
        logic             use_wheel;
        logic             use_div;
        logic [7:0]       wheel_pos;
        logic [RGB_W-1:0] rgb_fixed;
    } ctx_t;

    // 256-position wheel: red -> green -> blue -> red
    function automatic logic [RGB_W-1:0] wheel_color(input logic [7:0] pos);
        logic [7:0] w;
        logic [7:0] t;
        logic [9:0] m;
        logic [RGB_W-1:0] rgb;
        w = CHAN_FULL - pos;
        if (w < WHEEL_THIRD) begin
            t   = w;
            m   = 10'(t) * 10'd3;
            rgb = {CHAN_FULL - m[7:0], 8'd0, m[7:0]};
        end
        else if (w < WHEEL_TWO_THIRDS) begin
            t   = w - WHEEL_THIRD;
            m   = 10'(t) * 10'd3;
            rgb = {8'd0, m[7:0], CHAN_FULL - m[7:0]};
        end
        else begin
            t   = w - WHEEL_TWO_THIRDS;
            m   = 10'(t) * 10'd3;
            rgb = {m[7:0], CHAN_FULL - m[7:0], 8'd0};
        end
        return rgb;
    endfunction

    // Divisibility by three: base-4 digits each weigh 1 mod 3
    function automatic logic div_by_three(input logic [INDEX_W-1:0] v);
        logic [3:0] s1;
        logic [2:0] s2;
        s1 = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]) + 4'(v[9:8]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
        return (s2 == 3'd0) || (s2 == 3'd3) || (s2 == 3'd6);
    endfunction

    // Value modulo 255: 256 weighs 1 mod 255
    function automatic logic [7:0] mod_255(input logic [10:0] v);
        logic [8:0] t;
        logic [8:0] r;
        t = 9'(v[10:8]) + 9'(v[7:0]);
        r = (t >= 9'(CHAN_FULL)) ? t - 9'(CHAN_FULL) : t;
        return r[7:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/lspc_div_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Gives floor(rem_in * 256 / divisor) for rem_in < divisor, two bits a stage.
// ----------------------------------------------------------------------------
module lspc_div_pipe (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [lspc_pkg::COUNT_W-1:0]  in_rem,
    input  wire lspc_pkg::ctx_t                in_ctx,
    input  wire logic [lspc_pkg::COUNT_W-1:0]  divisor,
    output logic                               out_valid,
    output logic [lspc_pkg::QUO_W-1:0]         out_quo,
    output lspc_pkg::ctx_t                     out_ctx
);

    localparam int NS = lspc_pkg::DIV_STAGES;
    localparam int CW = lspc_pkg::COUNT_W;
    localparam int QW = lspc_pkg::QUO_W;

    logic           valid_reg [NS];
    logic [CW-1:0]  rem_reg   [NS];
    logic [QW-1:0]  quo_reg   [NS];
    lspc_pkg::ctx_t ctx_reg   [NS];

    logic [CW-1:0]  rem_next  [NS];
    logic [QW-1:0]  quo_next  [NS];

    always_comb
    begin
        logic [CW:0]   r;
        logic [CW-1:0] rr;
        logic [QW-1:0] q;
        for (int s = 0; s < NS; s++) begin
            rr = (s == 0) ? in_rem : rem_reg[(s == 0) ? 0 : s - 1];
            q  = (s == 0) ? '0     : quo_reg[(s == 0) ? 0 : s - 1];
            for (int b = 0; b < lspc_pkg::BITS_PER_STAGE; b++) begin
                r = {rr, 1'b0};
                if (r >= {1'b0, divisor}) begin
                    r = r - {1'b0, divisor};
                    q = {q[QW-2:0], 1'b1};
                end
                else begin
                    q = {q[QW-2:0], 1'b0};
                end
                rr = r[CW-1:0];
            end
            rem_next[s] = rr;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s < NS; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end
        else begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++) begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_next[0];
        quo_reg[0] <= quo_next[0];
        ctx_reg[0] <= in_ctx;
        for (int s = 1; s < NS; s++) begin
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
            ctx_reg[s] <= ctx_reg[s-1];
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_ctx   = ctx_reg[NS-1];

endmodule
`default_nettype wire

// ===== design/led_strip_pattern_pixel_color_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LED strip pattern pixel colour unit
// Streams one pixel colour per clock for the configured strip pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present frame_step, sub_phase and pixel_index with start
//   high; the item is taken at any edge where start is high and busy is low.
//   busy never rises, so a new item can enter on every clock.
//   Result channel: red, green, blue and pixel_lit appear for one cycle with
//   done high, in the order the items were taken.
//   Throughput is one item per clock; latency is set by the input register,
//   the decode stage, four divider stages (two quotient bits each, for the
//   rainbow cycle position) and the wheel/select output register.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Write only while no item is in flight.
//   Reset: mode rainbow, 64 pixels, white base colour; pipeline emptied.
//   The receiver cannot stall, so nothing is held back on the output side.
// ----------------------------------------------------------------------------
module led_strip_pattern_pixel_color_unit #(
    parameter int MAX_PIXELS = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // item input
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [lspc_pkg::STEP_W-1:0]     frame_step,
    input  wire logic [lspc_pkg::PHASE_W-1:0]    sub_phase,
    input  wire logic [lspc_pkg::INDEX_W-1:0]    pixel_index,
    // result output
    output logic                                 done,
    output logic [lspc_pkg::CHAN_W-1:0]          red,
    output logic [lspc_pkg::CHAN_W-1:0]          green,
    output logic [lspc_pkg::CHAN_W-1:0]          blue,
    output logic                                 pixel_lit,
    // configuration write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [lspc_pkg::RGB_W-1:0]      cfg_data
);

    localparam int CW = lspc_pkg::COUNT_W;
    localparam int IW = lspc_pkg::INDEX_W;
    localparam int SW = lspc_pkg::STEP_W;
    localparam int PW = lspc_pkg::PHASE_W;
    localparam int RW = lspc_pkg::RGB_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]    mode_reg;
    logic [CW-1:0] count_reg;
    logic [RW-1:0] base_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= lspc_pkg::MODE_RAINBOW;
            count_reg <= CW'(64);
            base_reg  <= 24'hFFFFFF;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lspc_pkg::CFG_PATTERN_MODE: mode_reg  <= cfg_data[2:0];
                lspc_pkg::CFG_PIXEL_COUNT:  count_reg <= cfg_data[CW-1:0];
                lspc_pkg::CFG_BASE_COLOR:   base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the strip length to the largest supported strip
    logic [CW-1:0] count_eff;
    always_comb
    begin
        if (13'(count_reg) > 13'(MAX_PIXELS)) begin
            count_eff = CW'(MAX_PIXELS);
        end
        else begin
            count_eff = count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: capture the item
    // ------------------------------------------------------------------
    logic          a_valid_reg;
    logic [SW-1:0] a_step_reg;
    logic [PW-1:0] a_phase_reg;
    logic [IW-1:0] a_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end
        else begin
            a_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_step_reg  <= frame_step;
        a_phase_reg <= sub_phase;
        a_index_reg <= pixel_index;
    end

    // ------------------------------------------------------------------
    // Stage B: decode the pattern, work out fixed colours, wheel positions
    // and the lit flag; seed the divider with the pixel index
    // ------------------------------------------------------------------
    lspc_pkg::ctx_t b_ctx_next;
    lspc_pkg::ctx_t b_ctx_reg;
    logic           b_valid_reg;
    logic [CW-1:0]  b_rem_reg;

    always_comb
    begin
        logic          in_range;
        logic          chase_hit;
        logic [IW-1:0] diff;
        logic [7:0]    pos_plain;
        logic [7:0]    pos_chase;
        in_range  = {1'b0, a_index_reg} < count_eff;
        diff      = a_index_reg - IW'(a_phase_reg);
        chase_hit = (a_index_reg >= IW'(a_phase_reg)) && lspc_pkg::div_by_three(diff);
        pos_plain = a_index_reg[7:0] + a_step_reg[7:0];
        pos_chase = lspc_pkg::mod_255(11'(diff) + 11'(a_step_reg));

        b_ctx_next.step_lo   = a_step_reg[7:0];
        b_ctx_next.lit       = 1'b0;
        b_ctx_next.use_wheel = 1'b0;
        b_ctx_next.use_div   = 1'b0;
        b_ctx_next.wheel_pos = pos_plain;
        b_ctx_next.rgb_fixed = '0;

        if (in_range) begin
            case (mode_reg)
                lspc_pkg::MODE_FILL:
                begin
                    b_ctx_next.lit       = 1'b1;
                    b_ctx_next.rgb_fixed = base_reg;
                end
                lspc_pkg::MODE_WIPE:
                begin
                    if (a_index_reg <= a_step_reg) begin
                        b_ctx_next.lit       = 1'b1;
                        b_ctx_next.rgb_fixed = base_reg;
                    end
                end
                lspc_pkg::MODE_POLICE:
                begin
                    b_ctx_next.lit       = 1'b1;
                    b_ctx_next.rgb_fixed = (a_index_reg[0] ^ a_phase_reg[0]) ?
                                           lspc_pkg::RGB_BLUE : lspc_pkg::RGB_RED;
                end
                lspc_pkg::MODE_RAINBOW:
                begin
                    b_ctx_next.lit       = 1'b1;
                    b_ctx_next.use_wheel = 1'b1;
                end
                lspc_pkg::MODE_RAINBOW_CYCLE:
                begin
                    b_ctx_next.lit       = 1'b1;
                    b_ctx_next.use_wheel = 1'b1;
                    b_ctx_next.use_div   = 1'b1;
                end
                lspc_pkg::MODE_CHASE:
                begin
                    if (chase_hit) begin
                        b_ctx_next.lit       = 1'b1;
                        b_ctx_next.rgb_fixed = base_reg;
                    end
                end
                lspc_pkg::MODE_CHASE_RAINBOW:
                begin
                    if (chase_hit) begin
                        b_ctx_next.lit       = 1'b1;
                        b_ctx_next.use_wheel = 1'b1;
                        b_ctx_next.wheel_pos = pos_chase;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
        end
        else begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_ctx_reg <= b_ctx_next;
        b_rem_reg <= CW'(a_index_reg);
    end

    // ------------------------------------------------------------------
    // Divider stages: index * 256 / count for the rainbow cycle spread
    // ------------------------------------------------------------------
    logic                         d_valid;
    logic [lspc_pkg::QUO_W-1:0]   d_quo;
    lspc_pkg::ctx_t               d_ctx;

    lspc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_rem    (b_rem_reg),
        .in_ctx    (b_ctx_reg),
        .divisor   (count_eff),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_ctx   (d_ctx)
    );

    // ------------------------------------------------------------------
    // Output stage: look up the wheel and select the final colour
    // ------------------------------------------------------------------
    logic [7:0]    w_pos;
    logic [RW-1:0] w_rgb_next;
    logic          out_valid_reg;
    logic [RW-1:0] out_rgb_reg;
    logic          out_lit_reg;

    always_comb
    begin
        w_pos      = d_ctx.use_div ? (d_quo + d_ctx.step_lo) : d_ctx.wheel_pos;
        w_rgb_next = d_ctx.use_wheel ? lspc_pkg::wheel_color(w_pos) : d_ctx.rgb_fixed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rgb_reg <= w_rgb_next;
        out_lit_reg <= d_ctx.lit;
    end

    assign done      = out_valid_reg;
    assign red       = out_rgb_reg[23:16];
    assign green     = out_rgb_reg[15:8];
    assign blue      = out_rgb_reg[7:0];
    assign pixel_lit = out_lit_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7))
        else $error("result without an item seven edges earlier");

    a_unlit_is_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pixel_lit) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
        else $error("unlit pixel carries colour");

    a_police_colours: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pixel_lit && mode_reg == lspc_pkg::MODE_POLICE) |->
        ((red == 8'hFF && green == 8'd0 && blue == 8'd0) ||
         (red == 8'd0 && green == 8'd0 && blue == 8'hFF)))
        else $error("police pattern gave a colour other than red or blue");

    a_unused_mode_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_reg == lspc_pkg::MODE_UNUSED) |-> !pixel_lit)
        else $error("unused pattern code lit a pixel");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED strip pattern pixel colour unit testbench
// Runs pixel requests through the unit under every pattern, several strip
// lengths and base colours, predicts each pixel's colour in the bench and
// checks every result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_PIXELS = 1024;

    // Register slot the package leaves unnamed
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    localparam int DRAIN_CYCLES    = 12;        // pipeline is seven registers deep
    localparam int RUN_LIMIT_NS    = 1_000_000;
    localparam int RANDOM_PHASES   = 22;
    localparam int ITEMS_PER_PHASE = 64;
    localparam int REPORT_LINES    = 100;

    typedef struct packed {
        logic [lspc_pkg::STEP_W-1:0]  step;
        logic [lspc_pkg::PHASE_W-1:0] phase;
        logic [lspc_pkg::INDEX_W-1:0] index;
    } pixel_req_t;

    typedef struct packed {
        pixel_req_t                  req;
        logic [lspc_pkg::CHAN_W-1:0] red;
        logic [lspc_pkg::CHAN_W-1:0] green;
        logic [lspc_pkg::CHAN_W-1:0] blue;
        logic                        lit;
    } pixel_colour_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          start       = 1'b0;
    logic [lspc_pkg::STEP_W-1:0]   frame_step  = '0;
    logic [lspc_pkg::PHASE_W-1:0]  sub_phase   = '0;
    logic [lspc_pkg::INDEX_W-1:0]  pixel_index = '0;
    logic                          cfg_valid   = 1'b0;
    logic [1:0]                    cfg_index   = '0;
    logic [lspc_pkg::RGB_W-1:0]    cfg_data    = '0;
    logic                          busy;
    logic                          done;
    logic [lspc_pkg::CHAN_W-1:0]   red;
    logic [lspc_pkg::CHAN_W-1:0]   green;
    logic [lspc_pkg::CHAN_W-1:0]   blue;
    logic                          pixel_lit;
    logic                          cfg_ready;

    // Bench copy of the configuration registers, reset values included
    logic [2:0]                    pattern_sel = lspc_pkg::MODE_RAINBOW;
    logic [lspc_pkg::COUNT_W-1:0]  strip_len   = 11'd64;
    logic [lspc_pkg::RGB_W-1:0]    fill_rgb    = 24'hFFFFFF;

    pixel_req_t          pixel_requests[$];   // items waiting for the driver
    pixel_colour_t       colour_expected[$];  // predicted colours in flight
    bit                  item_taken = 1'b0;   // set at the edge that takes an item
    int                  gap_left   = 0;
    int                  burst_left = 0;
    int                  mismatches = 0;

    led_strip_pattern_pixel_color_unit #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .frame_step  (frame_step),
        .sub_phase   (sub_phase),
        .pixel_index (pixel_index),
        .done        (done),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .pixel_lit   (pixel_lit),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Colour prediction
    // ------------------------------------------------------------------------

    // Colour wheel: position 0 is red, a third round green, two thirds blue.
    // Work on the reversed position as the unit does.
    function automatic logic [lspc_pkg::RGB_W-1:0] wheel_rgb(input int unsigned pos);
        int unsigned w;
        w = 255 - (pos % 256);
        if (w < 85)
            return {8'(255 - 3 * w), 8'd0, 8'(3 * w)};
        else if (w < 170)
            return {8'd0, 8'(3 * (w - 85)), 8'(255 - 3 * (w - 85))};
        else
            return {8'(3 * (w - 170)), 8'(255 - 3 * (w - 170)), 8'd0};
    endfunction

    // Chase lights every third pixel, counting from the sub-phase
    function automatic bit chase_hit(input int unsigned idx, input int unsigned ph);
        return (idx >= ph) && ((idx - ph) % 3 == 0);
    endfunction

    function automatic pixel_colour_t pixel_colour_predict(input pixel_req_t req);
        int unsigned   lanes;
        int unsigned   idx;
        int unsigned   stp;
        int unsigned   ph;
        logic [23:0]   rgb;
        logic          lit;
        pixel_colour_t res;
        // Counts above the strip maximum saturate; zero leaves every pixel dark
        lanes = (strip_len > MAX_PIXELS) ? MAX_PIXELS : strip_len;
        idx   = req.index;
        stp   = req.step;
        ph    = req.phase;
        rgb   = '0;
        lit   = 1'b0;
        if (idx < lanes)
        begin
            case (pattern_sel)
                lspc_pkg::MODE_FILL:
                begin
                    rgb = fill_rgb;
                    lit = 1'b1;
                end
                lspc_pkg::MODE_WIPE:
                begin
                    if (idx <= stp)
                    begin
                        rgb = fill_rgb;
                        lit = 1'b1;
                    end
                end
                lspc_pkg::MODE_POLICE:
                begin
                    // Odd sub-phase swaps red and blue
                    rgb = (((idx ^ ph) & 1) == 0) ? lspc_pkg::RGB_RED : lspc_pkg::RGB_BLUE;
                    lit = 1'b1;
                end
                lspc_pkg::MODE_RAINBOW:
                begin
                    rgb = wheel_rgb(idx + stp);
                    lit = 1'b1;
                end
                lspc_pkg::MODE_RAINBOW_CYCLE:
                begin
                    rgb = wheel_rgb((idx * 256) / lanes + stp);
                    lit = 1'b1;
                end
                lspc_pkg::MODE_CHASE:
                begin
                    if (chase_hit(idx, ph))
                    begin
                        rgb = fill_rgb;
                        lit = 1'b1;
                    end
                end
                lspc_pkg::MODE_CHASE_RAINBOW:
                begin
                    if (chase_hit(idx, ph))
                    begin
                        rgb = wheel_rgb((idx - ph + stp) % 255);
                        lit = 1'b1;
                    end
                end
                default:
                begin
                    // Spare pattern code stays dark
                end
            endcase
        end
        res.req   = req;
        res.red   = rgb[23:16];
        res.green = rgb[15:8];
        res.blue  = rgb[7:0];
        res.lit   = lit;
        return res;
    endfunction

    // Print the first REPORT_LINES mismatches in full, count all of them
    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_LINES)
            $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: present one item at each falling edge outside the random gaps, hold it until taken
    // ------------------------------------------------------------------------

    // Mostly back-to-back or short gaps, a few long ones, and now and then a
    // burst with no gaps at all
    function automatic int pick_gap();
        int unsigned r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        else if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    always @(negedge clk)
    begin : driver
        pixel_req_t req;
        if (rst_n)
        begin
            // Hold a presented item until the unit has taken it
            if (!start || item_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pixel_requests.size() > 0)
                begin
                    req = pixel_requests.pop_front();
                    start       <= 1'b1;
                    frame_step  <= req.step;
                    sub_phase   <= req.phase;
                    pixel_index <= req.index;
                    gap_left = pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: track register writes and taken items, check result strobes
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        pixel_req_t    req;
        pixel_colour_t want;
        item_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lspc_pkg::CFG_PATTERN_MODE: pattern_sel = cfg_data[2:0];
                    lspc_pkg::CFG_PIXEL_COUNT:  strip_len   = cfg_data[lspc_pkg::COUNT_W-1:0];
                    lspc_pkg::CFG_BASE_COLOR:   fill_rgb    = cfg_data;
                    default:
                    begin
                        // Spare slot: write is dropped
                    end
                endcase
            end

            if (start && !busy)
            begin
                req.step  = frame_step;
                req.phase = sub_phase;
                req.index = pixel_index;
                colour_expected.push_back(pixel_colour_predict(req));
                item_taken = 1'b1;
            end

            if (done)
            begin
                if (colour_expected.size() == 0)
                    report_mismatch($sformatf("result %02h%02h%02h lit %0b with no item in flight",
                                              red, green, blue, pixel_lit));
                else
                begin
                    want = colour_expected.pop_front();
                    if (red !== want.red)
                        report_mismatch($sformatf("step %0d phase %0d pixel %0d: red %02h, want %02h",
                                                  want.req.step, want.req.phase, want.req.index,
                                                  red, want.red));
                    if (green !== want.green)
                        report_mismatch($sformatf("step %0d phase %0d pixel %0d: green %02h, want %02h",
                                                  want.req.step, want.req.phase, want.req.index,
                                                  green, want.green));
                    if (blue !== want.blue)
                        report_mismatch($sformatf("step %0d phase %0d pixel %0d: blue %02h, want %02h",
                                                  want.req.step, want.req.phase, want.req.index,
                                                  blue, want.blue));
                    if (pixel_lit !== want.lit)
                        report_mismatch($sformatf("step %0d phase %0d pixel %0d: lit %0b, want %0b",
                                                  want.req.step, want.req.phase, want.req.index,
                                                  pixel_lit, want.lit));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_item(input int unsigned step, input int unsigned phase,
                            input int unsigned index);
        pixel_req_t req;
        req.step  = lspc_pkg::STEP_W'(step);
        req.phase = lspc_pkg::PHASE_W'(phase);
        req.index = lspc_pkg::INDEX_W'(index);
        pixel_requests.push_back(req);
    endtask

    // Drain the unit: nothing queued, nothing presented, nothing in flight
    task automatic wait_idle();
        while (pixel_requests.size() != 0 || start || colour_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index,
                             input logic [lspc_pkg::RGB_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Unused upper data bits carry noise: the unit must ignore them
    task automatic set_pattern(input logic [2:0] mode,
                               input logic [lspc_pkg::COUNT_W-1:0] count,
                               input logic [lspc_pkg::RGB_W-1:0] colour);
        write_reg(lspc_pkg::CFG_PATTERN_MODE, {21'($urandom), mode});
        write_reg(lspc_pkg::CFG_PIXEL_COUNT, {13'($urandom), count});
        write_reg(lspc_pkg::CFG_BASE_COLOR, colour);
    endtask

    initial
    begin : stimulus
        int unsigned                  sel;
        int unsigned                  lanes;
        int unsigned                  idx;
        int unsigned                  stp;
        logic [2:0]                   mode;
        logic [lspc_pkg::COUNT_W-1:0] count;
        logic [lspc_pkg::RGB_W-1:0]   colour;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: rainbow over 64 pixels; field extremes, last pixel
        // and the first pixel beyond the strip
        add_item(0, 0, 0);
        add_item(1023, 3, 63);
        add_item(1023, 3, 64);
        add_item(255, 2, 1023);

        // Fill with black colour over a saturated count: lit stays high
        wait_idle();
        set_pattern(lspc_pkg::MODE_FILL, 11'd2047, 24'h000000);
        add_item(0, 0, 1023);
        add_item(5, 1, 0);

        // Wipe: front exactly at the pixel, just past it, and at the far end
        wait_idle();
        set_pattern(lspc_pkg::MODE_WIPE, 11'd1024, 24'h123456);
        add_item(10, 0, 10);
        add_item(10, 0, 11);
        add_item(1023, 0, 1023);

        // Police: both parities, sub-phase three, edge of a 1000 pixel strip
        wait_idle();
        set_pattern(lspc_pkg::MODE_POLICE, 11'd1000, 24'hABCDEF);
        add_item(0, 0, 0);
        add_item(0, 1, 0);
        add_item(0, 3, 1);
        add_item(0, 2, 999);
        add_item(0, 2, 1000);

        // Rainbow cycle on a tiny strip
        wait_idle();
        set_pattern(lspc_pkg::MODE_RAINBOW_CYCLE, 11'd3, 24'h000000);
        add_item(0, 0, 0);
        add_item(0, 0, 1);
        add_item(1023, 0, 2);

        // Chase with sub-phase three, below the offset and at the top pixel
        wait_idle();
        set_pattern(lspc_pkg::MODE_CHASE, 11'd1024, 24'hFF00FF);
        add_item(0, 3, 3);
        add_item(0, 3, 2);
        add_item(0, 2, 1022);
        add_item(0, 0, 1023);

        // Chase rainbow: wheel position wraps at 255
        wait_idle();
        set_pattern(lspc_pkg::MODE_CHASE_RAINBOW, 11'd1024, 24'hFFFFFF);
        add_item(1023, 0, 1023);
        add_item(0, 3, 0);
        add_item(254, 1, 1);

        // Spare pattern code, then an empty strip
        wait_idle();
        set_pattern(lspc_pkg::MODE_UNUSED, 11'd1024, 24'hFFFFFF);
        add_item(5, 0, 5);
        wait_idle();
        set_pattern(lspc_pkg::MODE_FILL, 11'd0, 24'hFFFFFF);
        add_item(0, 0, 0);

        // Random phases: fresh settings, then a run of pixels biased towards
        // the lit part of the strip and its end
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       count = 11'd0;
                1:       count = 11'($urandom_range(1, 3));
                2:       count = 11'd1024;
                3:       count = 11'($urandom_range(1025, 2047));
                4:       count = 11'd2047;
                default: count = 11'($urandom_range(1, 1024));
            endcase
            sel = $urandom_range(0, 7);
            colour = (sel == 0) ? 24'h000000 : (sel == 1) ? 24'hFFFFFF : 24'($urandom);
            mode   = 3'($urandom_range(0, 7));
            lanes  = (count > MAX_PIXELS) ? MAX_PIXELS : count;

            wait_idle();
            set_pattern(mode, count, colour);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, 24'($urandom));

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 4 || lanes == 0)
                    idx = $urandom_range(0, 1023);
                else if (sel < 8)
                    idx = $urandom_range(0, lanes - 1);
                else
                    idx = lanes - 1 + $urandom_range(0, 2);
                if (idx > 1023)
                    idx = 1023;
                // Put the wipe front close to the pixel now and then
                if ($urandom_range(0, 9) < 3)
                begin
                    stp = idx + $urandom_range(0, 4);
                    stp = (stp < 2) ? 0 : stp - 2;
                    if (stp > 1023)
                        stp = 1023;
                end
                else
                    stp = $urandom_range(0, 1023);
                add_item(stp, $urandom_range(0, 3), idx);
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("PASS led_strip_pattern_pixel_color_unit");
        else
            $display("FAIL led_strip_pattern_pixel_color_unit");
        $finish;
    end

    // Hard stop if results stop coming
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL led_strip_pattern_pixel_color_unit");
        $finish;
    end

endmodule
